@@ sv/mm_pkg.sv @@
package mm_pkg;

  localparam int DEFAULT_MAX_DIM    = 8;
  localparam int DEFAULT_ELEM_WIDTH = 16;

  // Configuration port.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Result fields.
  localparam int PROD_W    = 35;
  localparam int IDX_OUT_W = 3;

  // Control that travels with one multiply-accumulate through the datapath.
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    logic                 last_entry;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
  } mac_ctl_t;

endpackage

@@ sv/mm_mem.sv @@
module mm_mem
  import mm_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM,
  parameter int WIDTH  = DEFAULT_ELEM_WIDTH,
  parameter int ADDR_W = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]       raddr,
  output logic signed [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mm_mac.sv @@
module mm_mac
  import mm_pkg::*;
#(
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [ELEM_WIDTH-1:0] a_data,
  input  logic signed [ELEM_WIDTH-1:0] b_data,
  input  mac_ctl_t                     ctl,
  input  logic                         err,
  output logic                         strobe,
  output logic signed [PROD_W-1:0]     product_value,
  output logic [IDX_OUT_W-1:0]         row_index,
  output logic [IDX_OUT_W-1:0]         col_index,
  output logic                         last_entry,
  output logic                         overfill_error
);

  localparam int MUL_W = 2 * ELEM_WIDTH;
  localparam int EXT_W = (MUL_W > PROD_W) ? MUL_W : PROD_W;

  logic signed [MUL_W-1:0]  mult;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] acc_sum;
  mac_ctl_t                 ctl_p;

  assign mult = a_data * b_data;

  // The first term of an entry restarts the sum; it wraps modulo 2^PROD_W.
  assign acc_sum = (ctl_p.first ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p  <= '0;
      strobe <= 1'b0;
    end else begin
      ctl_p <= ctl;
      prod  <= PROD_W'(EXT_W'(mult));
      if (ctl_p.valid) begin
        acc <= acc_sum;
      end
      if (err) begin
        strobe         <= 1'b1;
        product_value  <= '0;
        row_index      <= '0;
        col_index      <= '0;
        last_entry     <= 1'b0;
        overfill_error <= 1'b1;
      end else if (ctl_p.valid && ctl_p.last) begin
        strobe         <= 1'b1;
        product_value  <= acc_sum;
        row_index      <= ctl_p.row;
        col_index      <= ctl_p.col;
        last_entry     <= ctl_p.last_entry;
        overfill_error <= 1'b0;
      end else begin
        strobe <= 1'b0;
      end
    end
  end

endmodule

@@ sv/mm_ctrl.sv @@
module mm_ctrl
  import mm_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 which_matrix,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output logic                 we_a,
  output logic                 we_b,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] waddr,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_a,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_b,
  output mac_ctl_t             ctl,
  output logic                 err
);

  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int SZ_W   = 2 * DIM_W;

  typedef enum logic [1:0] {
    IDLE,
    COMPUTE,
    DRAIN
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   rows_a;
  logic [CFG_W-1:0]   inner_dim;
  logic [CFG_W-1:0]   cols_b;
  logic [CNT_W-1:0]   count_a;
  logic [CNT_W-1:0]   count_b;
  logic [IDX_W-1:0]   i_idx;
  logic [IDX_W-1:0]   j_idx;
  logic [IDX_W-1:0]   k_idx;
  logic [ADDR_W-1:0]  a_base;
  logic [ADDR_W-1:0]  b_addr;
  logic               drain;

  logic [DIM_W-1:0]   r;
  logic [DIM_W-1:0]   n;
  logic [DIM_W-1:0]   c;
  logic [SZ_W-1:0]    size_a;
  logic [SZ_W-1:0]    size_b;
  logic               accept;
  logic               over_a;
  logic               over_b;
  logic [CNT_W-1:0]   count_a_next;
  logic [CNT_W-1:0]   count_b_next;
  logic               full;
  logic               i_last;
  logic               j_last;
  logic               k_last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] v;
    v = d;
    if (d == '0) begin
      v = CFG_W'(1);
    end else if (d > CFG_W'(MAX_DIM)) begin
      v = CFG_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  assign r      = clamp_dim(rows_a);
  assign n      = clamp_dim(inner_dim);
  assign c      = clamp_dim(cols_b);
  assign size_a = SZ_W'(r) * SZ_W'(n);
  assign size_b = SZ_W'(n) * SZ_W'(c);

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign over_a = SZ_W'(count_a) >= size_a;
  assign over_b = SZ_W'(count_b) >= size_b;

  assign we_a  = accept && !which_matrix && !over_a;
  assign we_b  = accept && which_matrix && !over_b;
  assign err   = accept && (which_matrix ? over_b : over_a);
  assign waddr = which_matrix ? count_b[ADDR_W-1:0] : count_a[ADDR_W-1:0];

  assign count_a_next = count_a + CNT_W'(we_a);
  assign count_b_next = count_b + CNT_W'(we_b);
  assign full = (SZ_W'(count_a_next) >= size_a) && (SZ_W'(count_b_next) >= size_b);

  assign i_last = (i_idx == IDX_W'(r - DIM_W'(1)));
  assign j_last = (j_idx == IDX_W'(c - DIM_W'(1)));
  assign k_last = (k_idx == IDX_W'(n - DIM_W'(1)));

  // A row of A starts at a_base; a column of B is walked in steps of c.
  assign raddr_a = a_base + ADDR_W'(k_idx);
  assign raddr_b = b_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rows_a    <= CFG_W'(1);
      inner_dim <= CFG_W'(1);
      cols_b    <= CFG_W'(1);
      count_a   <= '0;
      count_b   <= '0;
      i_idx     <= '0;
      j_idx     <= '0;
      k_idx     <= '0;
      a_base    <= '0;
      b_addr    <= '0;
      drain     <= 1'b0;
      ctl       <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ROWS_A:    rows_a    <= wr_data;
          REG_INNER_DIM: inner_dim <= wr_data;
          REG_COLS_B:    cols_b    <= wr_data;
          default: ;
        endcase
      end

      ctl.valid      <= (state == COMPUTE);
      ctl.first      <= (k_idx == '0);
      ctl.last       <= k_last;
      ctl.last_entry <= i_last && j_last;
      ctl.row        <= IDX_OUT_W'(i_idx);
      ctl.col        <= IDX_OUT_W'(j_idx);

      case (state)
        IDLE: begin
          if (accept && !err) begin
            if (full) begin
              count_a <= '0;
              count_b <= '0;
              i_idx   <= '0;
              j_idx   <= '0;
              k_idx   <= '0;
              a_base  <= '0;
              b_addr  <= '0;
              state   <= COMPUTE;
            end else begin
              count_a <= count_a_next;
              count_b <= count_b_next;
            end
          end
        end
        COMPUTE: begin
          if (!k_last) begin
            k_idx  <= k_idx + IDX_W'(1);
            b_addr <= b_addr + ADDR_W'(c);
          end else begin
            k_idx <= '0;
            if (!j_last) begin
              j_idx  <= j_idx + IDX_W'(1);
              b_addr <= ADDR_W'(j_idx) + ADDR_W'(1);
            end else begin
              j_idx  <= '0;
              b_addr <= '0;
              i_idx  <= i_idx + IDX_W'(1);
              a_base <= a_base + ADDR_W'(n);
              if (i_last) begin
                drain <= 1'b0;
                state <= DRAIN;
              end
            end
          end
        end
        DRAIN: begin
          // The last product leaves the output register before new loads.
          drain <= 1'b1;
          if (drain) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ sv/matrix_multiply.sv @@
// Load: one element per cycle while busy is low; an overfilled element yields
// its error result with the strobe in the cycle after it is taken.
// The element that completes both matrices raises busy; one result follows for each
// entry of the rows_a by cols_b product (sizes clamped to 1..MAX_DIM), row by row.
// One multiplier and one accumulator do all the work, one product per cycle.
// Synchronous reset clears counts and sets all sizes to 1; the receiver cannot stall.
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = DEFAULT_MAX_DIM,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         which_matrix,
  input  logic signed [ELEM_WIDTH-1:0] element_value,
  input  logic                         wr_en,
  input  logic [CFG_IDX_W-1:0]         wr_index,
  input  logic [CFG_W-1:0]             wr_data,
  output logic                         strobe,
  output logic signed [PROD_W-1:0]     product_value,
  output logic [IDX_OUT_W-1:0]         row_index,
  output logic [IDX_OUT_W-1:0]         col_index,
  output logic                         last_entry,
  output logic                         overfill_error
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

  logic                         we_a;
  logic                         we_b;
  logic [ADDR_W-1:0]            waddr;
  logic [ADDR_W-1:0]            raddr_a;
  logic [ADDR_W-1:0]            raddr_b;
  logic signed [ELEM_WIDTH-1:0] a_data;
  logic signed [ELEM_WIDTH-1:0] b_data;
  mac_ctl_t                     ctl;
  logic                         err;

  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .which_matrix (which_matrix),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .we_a         (we_a),
    .we_b         (we_b),
    .waddr        (waddr),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b),
    .ctl          (ctl),
    .err          (err)
  );

  mm_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (ELEM_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  mm_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (ELEM_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  mm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk            (clk),
    .rst            (rst),
    .a_data         (a_data),
    .b_data         (b_data),
    .ctl            (ctl),
    .err            (err),
    .strobe         (strobe),
    .product_value  (product_value),
    .row_index      (row_index),
    .col_index      (col_index),
    .last_entry     (last_entry),
    .overfill_error (overfill_error)
  );

endmodule
